>>> rtl/hdpd_pkg.sv
// ----------------------------------------------------------------------------
// hdpd_pkg
// Shared widths, limits and register codes for the heading PD controller.
// ----------------------------------------------------------------------------
package hdpd_pkg;

   localparam int HEADING_W  = 13;
   localparam int GAIN_W     = 16;
   localparam int CAM_W      = 10;
   localparam int TF_W       = 16;
   localparam int ERR_W      = 13;
   localparam int DELTA_W    = 14;
   localparam int DRIVE_W    = 12;
   localparam int DTERM_W    = 8;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // shared multiplier: signed A by unsigned B
   localparam int MUL_A_W    = 31;
   localparam int MUL_B_W    = 16;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W + 1;

   localparam int HALF_TURN  = 2880;
   localparam int FULL_TURN  = 5760;
   localparam int P_CLAMP    = 150;
   localparam int D_CLAMP    = 100;
   localparam int OUT_LIMIT  = 2047;

   localparam int TARGET_RESET = 0;
   localparam int GAIN_RESET   = 256;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TARGET = 2'd0,
      CSR_P_GAIN = 2'd1,
      CSR_D_GAIN = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_HOLD   = 1'b0,
      OP_CAMERA = 1'b1
   } op_type;

endpackage

>>> rtl/hdpd_mul.sv
// ----------------------------------------------------------------------------
// hdpd_mul
// Shared signed-by-unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module hdpd_mul #(
   parameter int A_W = hdpd_pkg::MUL_A_W,
   parameter int B_W = hdpd_pkg::MUL_B_W,
   parameter int P_W = A_W + B_W + 1
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [A_W-1:0] a,
   input  logic        [B_W-1:0] b,
   output logic signed [P_W-1:0] prod
);
   import hdpd_pkg::*;

   logic signed [P_W-1:0] prod_ff;
   logic signed [P_W-1:0] prod_in;

   always_comb begin
      prod_in = prod_ff;
      if (en) begin
         prod_in = P_W'(a * $signed({1'b0, b}));
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> rtl/heading_pd_controller_core.sv
// ----------------------------------------------------------------------------
// heading_pd_controller_core
// Heading-hold / camera-tracking PD controller with clamped terms and a
// saturated drive, built around one shared registered multiplier.
// ----------------------------------------------------------------------------
//   channel   ports         direction   handshake
//   request   req_*         in          req_valid / req_ready
//   response  rsp_*         out         rsp_valid / rsp_ready
//   config    csr_*         in          csr_we, no wait
//
// A word goes through the error step, the three passes through the shared
// multiplier (P product, error change times time factor, times D gain), the D
// scaling step and the output step, one state each; the result shows in the same
// cycle req_ready goes high again. req_ready is low while a word is in work. A
// stalled response holds only the output step; a new word can be taken while an
// earlier result waits. Reset is synchronous and restores the register defaults
// and a zero previous error.
// ----------------------------------------------------------------------------
module heading_pd_controller_core (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_operation,
   input  logic        [hdpd_pkg::HEADING_W-1:0] req_heading,
   input  logic signed [hdpd_pkg::CAM_W-1:0]     req_cam_offset,
   input  logic        [hdpd_pkg::TF_W-1:0]      req_time_factor,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [hdpd_pkg::DRIVE_W-1:0]   rsp_drive,
   output logic signed [hdpd_pkg::DRIVE_W-1:0]   rsp_p_term,
   output logic signed [hdpd_pkg::DTERM_W-1:0]   rsp_d_term,
   output logic signed [hdpd_pkg::ERR_W-1:0]     rsp_heading_error,
   output logic                               rsp_saturated,

   input  logic                               csr_we,
   input  logic        [hdpd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic        [hdpd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hdpd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_ERR, S_MUL_P, S_MUL_D1, S_MUL_D2, S_DTERM, S_OUT
   } state_type;

   localparam int PW = 19;   // P before output saturation
   localparam int SW = 20;   // drive sum

   localparam logic signed [14:0] HALF_S  = 15'(HALF_TURN);
   localparam logic signed [14:0] FULL_S  = 15'(FULL_TURN);
   localparam logic signed [MUL_P_W-1:0] BIAS8  = MUL_P_W'((1 << 8) - 1);
   localparam logic signed [MUL_P_W-1:0] BIAS12 = MUL_P_W'((1 << 12) - 1);
   localparam logic signed [MUL_P_W-1:0] BIAS20 = MUL_P_W'((1 << 20) - 1);
   localparam logic signed [MUL_P_W-1:0] NO_BIAS = MUL_P_W'(0);
   localparam logic signed [MUL_P_W-1:0] P_CLAMP_S = MUL_P_W'(P_CLAMP);
   localparam logic signed [MUL_P_W-1:0] D_CLAMP_S = MUL_P_W'(D_CLAMP);
   localparam logic signed [SW-1:0] OUT_LIM_S = SW'(OUT_LIMIT);

   // config registers
   logic [HEADING_W-1:0] target_ff, target_in;
   logic [GAIN_W-1:0]    p_gain_ff, p_gain_in;
   logic [GAIN_W-1:0]    d_gain_ff, d_gain_in;

   // sequencer and working registers
   state_type               state_ff, state_in;
   logic                    op_ff, op_in;
   logic [HEADING_W-1:0]    heading_ff, heading_in;
   logic signed [CAM_W-1:0] cam_ff, cam_in;
   logic [TF_W-1:0]         tf_ff, tf_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [ERR_W-1:0] prev_err_ff, prev_err_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic signed [PW-1:0]    p_ff, p_in;
   logic signed [DTERM_W-1:0] d_ff, d_in;

   // response registers
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DRIVE_W-1:0] rsp_drive_ff, rsp_drive_in;
   logic signed [DRIVE_W-1:0] rsp_p_ff, rsp_p_in;
   logic signed [DTERM_W-1:0] rsp_d_ff, rsp_d_in;
   logic signed [ERR_W-1:0]   rsp_err_ff, rsp_err_in;
   logic                      rsp_sat_ff, rsp_sat_in;

   // multiplier
   logic                      mul_en;
   logic signed [MUL_A_W-1:0] mul_a;
   logic        [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod;

   // combinational datapath
   logic signed [14:0]        err_raw;
   logic signed [14:0]        err_wrap;
   logic signed [MUL_P_W-1:0] q_hold;
   logic signed [MUL_P_W-1:0] q_cam;
   logic signed [MUL_P_W-1:0] p_neg;
   logic signed [MUL_P_W-1:0] q_d;
   logic signed [MUL_P_W-1:0] d_neg;
   logic signed [SW-1:0]      sum;
   logic signed [SW-1:0]      p_wide;
   logic                      drive_hit;
   logic                      p_hit;
   logic                      rsp_load;

   hdpd_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W),
      .P_W (MUL_P_W)
   ) u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      err_raw  = $signed({2'b00, heading_ff}) - $signed({2'b00, target_ff});
      err_wrap = err_raw;
      if (err_raw > HALF_S) begin
         err_wrap = err_raw - FULL_S;
      end else if (err_raw < -HALF_S) begin
         err_wrap = err_raw + FULL_S;
      end

      // divides truncate toward zero: bias negative products before the shift
      q_hold = (prod + (prod[MUL_P_W-1] ? BIAS12 : NO_BIAS)) >>> 12;
      q_cam  = (prod + (prod[MUL_P_W-1] ? BIAS8  : NO_BIAS)) >>> 8;
      q_d    = (prod + (prod[MUL_P_W-1] ? BIAS20 : NO_BIAS)) >>> 20;
      p_neg  = -q_hold;
      d_neg  = -q_d;

      p_wide = SW'(p_ff);
      if (op_type'(op_ff) == OP_CAMERA) begin
         sum = p_wide - SW'(d_ff);
      end else begin
         sum = p_wide + SW'(d_ff);
      end
      drive_hit = (sum > OUT_LIM_S) || (sum < -OUT_LIM_S);
      p_hit = (op_type'(op_ff) == OP_CAMERA) &&
              ((p_wide > OUT_LIM_S) || (p_wide < -OUT_LIM_S));
   end

   always_comb begin
      mul_en = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         S_MUL_P: begin
            mul_en = 1'b1;
            mul_b  = p_gain_ff;
            if (op_type'(op_ff) == OP_CAMERA) begin
               mul_a = MUL_A_W'(cam_ff);
            end else begin
               mul_a = MUL_A_W'(err_ff);
            end
         end
         S_MUL_D1: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_W'(delta_ff);
            mul_b  = tf_ff;
         end
         S_MUL_D2: begin
            // error change times time factor fits in 30 bits
            mul_en = 1'b1;
            mul_a  = prod[MUL_A_W-1:0];
            mul_b  = d_gain_ff;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      target_in    = target_ff;
      p_gain_in    = p_gain_ff;
      d_gain_in    = d_gain_ff;
      state_in     = state_ff;
      op_in        = op_ff;
      heading_in   = heading_ff;
      cam_in       = cam_ff;
      tf_in        = tf_ff;
      err_in       = err_ff;
      prev_err_in  = prev_err_ff;
      delta_in     = delta_ff;
      p_in         = p_ff;
      d_in         = d_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_drive_in = rsp_drive_ff;
      rsp_p_in     = rsp_p_ff;
      rsp_d_in     = rsp_d_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_sat_in   = rsp_sat_ff;

      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_TARGET: target_in = csr_wdata[HEADING_W-1:0];
            CSR_P_GAIN: p_gain_in = csr_wdata[GAIN_W-1:0];
            CSR_D_GAIN: d_gain_in = csr_wdata[GAIN_W-1:0];
            default:    target_in = target_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_operation;
               heading_in = req_heading;
               cam_in     = req_cam_offset;
               tf_in      = req_time_factor;
               state_in   = S_ERR;
            end
         end
         S_ERR: begin
            err_in   = err_wrap[ERR_W-1:0];
            delta_in = DELTA_W'(err_wrap) - DELTA_W'(prev_err_ff);
            state_in = S_MUL_P;
         end
         S_MUL_D1: begin
            if (op_type'(op_ff) == OP_CAMERA) begin
               p_in = q_cam[PW-1:0];
            end else if (p_neg > P_CLAMP_S) begin
               p_in = PW'(P_CLAMP);
            end else if (p_neg < -P_CLAMP_S) begin
               p_in = -PW'(P_CLAMP);
            end else begin
               p_in = p_neg[PW-1:0];
            end
            state_in = S_MUL_D2;
         end
         S_MUL_P:  state_in = S_MUL_D1;
         S_MUL_D2: state_in = S_DTERM;
         S_DTERM: begin
            if (d_neg > D_CLAMP_S) begin
               d_in = DTERM_W'(D_CLAMP);
            end else if (d_neg < -D_CLAMP_S) begin
               d_in = -DTERM_W'(D_CLAMP);
            end else begin
               d_in = d_neg[DTERM_W-1:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_load) begin
               if (sum > OUT_LIM_S) begin
                  rsp_drive_in = DRIVE_W'(OUT_LIMIT);
               end else if (sum < -OUT_LIM_S) begin
                  rsp_drive_in = -DRIVE_W'(OUT_LIMIT);
               end else begin
                  rsp_drive_in = sum[DRIVE_W-1:0];
               end
               if (p_wide > OUT_LIM_S) begin
                  rsp_p_in = DRIVE_W'(OUT_LIMIT);
               end else if (p_wide < -OUT_LIM_S) begin
                  rsp_p_in = -DRIVE_W'(OUT_LIMIT);
               end else begin
                  rsp_p_in = p_wide[DRIVE_W-1:0];
               end
               rsp_d_in     = d_ff;
               rsp_err_in   = err_ff;
               rsp_sat_in   = drive_hit || p_hit;
               rsp_valid_in = 1'b1;
               prev_err_in  = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         target_ff    <= HEADING_W'(TARGET_RESET);
         p_gain_ff    <= GAIN_W'(GAIN_RESET);
         d_gain_ff    <= GAIN_W'(GAIN_RESET);
         prev_err_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         target_ff    <= target_in;
         p_gain_ff    <= p_gain_in;
         d_gain_ff    <= d_gain_in;
         prev_err_ff  <= prev_err_in;
      end
      op_ff        <= op_in;
      heading_ff   <= heading_in;
      cam_ff       <= cam_in;
      tf_ff        <= tf_in;
      err_ff       <= err_in;
      delta_ff     <= delta_in;
      p_ff         <= p_in;
      d_ff         <= d_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_p_ff     <= rsp_p_in;
      rsp_d_ff     <= rsp_d_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive         = rsp_drive_ff;
   assign rsp_p_term        = rsp_p_ff;
   assign rsp_d_term        = rsp_d_ff;
   assign rsp_heading_error = rsp_err_ff;
   assign rsp_saturated     = rsp_sat_ff;

   // a taken word keeps the block busy through the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a word is in work");

   // after each response load, the stored error matches the error of the word loaded
   a_prev_tracks_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_heading_error == prev_err_ff) && rsp_valid)
      else $error("previous error out of step with response");

   a_d_term_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_d_term <= 8'sd100) && (rsp_d_term >= -8'sd100))
      else $error("d term outside clamp");

endmodule

>>> tb/tb_heading_pd_controller_core.sv
// ----------------------------------------------------------------------------
// tb_heading_pd_controller_core
// Self-checking bench for the heading PD controller. A directed table covers
// the reset defaults, heading wrap at the half turn, P/D clamps and camera
// saturation. Random phases under varied gains and targets follow. Each
// response word is matched to a table value or an in-bench control law model.
// ----------------------------------------------------------------------------
module tb_heading_pd_controller_core;
   import hdpd_pkg::*;

   localparam longint HOLD_P_DIV = 4096;
   localparam longint CAM_P_DIV  = 256;
   localparam longint D_DIV      = 1048576;
   localparam int     PHASES     = 8;
   localparam int     PHASE_LEN  = 240;

   typedef struct {
      logic signed [DRIVE_W-1:0] drive;
      logic signed [DRIVE_W-1:0] p_term;
      logic signed [DTERM_W-1:0] d_term;
      logic signed [ERR_W-1:0]   heading_error;
      logic                      saturated;
   } pd_result_type;

   typedef enum bit {ROW_WORD, ROW_REGS} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      op_type                    op;
      logic [HEADING_W-1:0]      heading;
      logic signed [CAM_W-1:0]   cam;
      logic [TF_W-1:0]           tf;
      logic [CSR_DATA_W-1:0]     target;
      logic [CSR_DATA_W-1:0]     p_gain;
      logic [CSR_DATA_W-1:0]     d_gain;
      bit                        known;
      pd_result_type             want;
   } stim_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_operation = 1'b0;
   logic [HEADING_W-1:0]         req_heading = '0;
   logic signed [CAM_W-1:0]      req_cam_offset = '0;
   logic [TF_W-1:0]              req_time_factor = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [DRIVE_W-1:0]    rsp_drive;
   logic signed [DRIVE_W-1:0]    rsp_p_term;
   logic signed [DTERM_W-1:0]    rsp_d_term;
   logic signed [ERR_W-1:0]      rsp_heading_error;
   logic                         rsp_saturated;
   logic                         csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]        csr_addr = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   // model state and register mirror
   logic [HEADING_W-1:0]         cfg_target = HEADING_W'(TARGET_RESET);
   logic [GAIN_W-1:0]            cfg_p_gain = GAIN_W'(GAIN_RESET);
   logic [GAIN_W-1:0]            cfg_d_gain = GAIN_W'(GAIN_RESET);
   longint                       last_error = 0;

   pd_result_type                pd_outputs_due[$];
   pd_result_type                head_word;
   stim_row_type                 stim_table[$];
   int                           fail_count = 0;
   bit                           no_idle = 1'b0;
   int                           rsp_hold = 0;

   heading_pd_controller_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_heading       (req_heading),
      .req_cam_offset    (req_cam_offset),
      .req_time_factor   (req_time_factor),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive         (rsp_drive),
      .rsp_p_term        (rsp_p_term),
      .rsp_d_term        (rsp_d_term),
      .rsp_heading_error (rsp_heading_error),
      .rsp_saturated     (rsp_saturated),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

   function automatic longint clip(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // one control step; advances the stored error
   function automatic pd_result_type predict_pd_outputs(input op_type op,
                                                        input logic [HEADING_W-1:0] hd,
                                                        input logic signed [CAM_W-1:0] cam,
                                                        input logic [TF_W-1:0] tf);
      pd_result_type r;
      longint err, delta, p, d, raw, drv;
      bit sat;
      err = longint'(hd) - longint'(cfg_target);
      if (err > HALF_TURN) err -= FULL_TURN;
      else if (err < -HALF_TURN) err += FULL_TURN;
      delta = err - last_error;
      d = clip(-((delta * longint'(tf) * longint'(cfg_d_gain)) / D_DIV), D_CLAMP);
      if (op == OP_CAMERA) begin
         p   = (longint'(cam) * longint'(cfg_p_gain)) / CAM_P_DIV;
         raw = p - d;
         drv = clip(raw, OUT_LIMIT);
         sat = (drv != raw) || (clip(p, OUT_LIMIT) != p);
         p   = clip(p, OUT_LIMIT);
      end else begin
         p   = clip(-((err * longint'(cfg_p_gain)) / HOLD_P_DIV), P_CLAMP);
         raw = p + d;
         drv = clip(raw, OUT_LIMIT);
         sat = (drv != raw);
      end
      last_error = err;
      r.drive         = drv[DRIVE_W-1:0];
      r.p_term        = p[DRIVE_W-1:0];
      r.d_term        = d[DTERM_W-1:0];
      r.heading_error = err[ERR_W-1:0];
      r.saturated     = sat;
      return r;
   endfunction

   function automatic void regs_row(input int t, input int p, input int d);
      stim_row_type r;
      r.kind   = ROW_REGS;
      r.target = CSR_DATA_W'(t);
      r.p_gain = CSR_DATA_W'(p);
      r.d_gain = CSR_DATA_W'(d);
      r.known  = 1'b0;
      stim_table.push_back(r);
   endfunction

   function automatic void word_row(input op_type op, input int hd, input int cam,
                                    input int tf);
      stim_row_type r;
      r.kind    = ROW_WORD;
      r.op      = op;
      r.heading = HEADING_W'(hd);
      r.cam     = CAM_W'(cam);
      r.tf      = TF_W'(tf);
      r.known   = 1'b0;
      stim_table.push_back(r);
   endfunction

   // row whose outcome is plain from the control law
   function automatic void known_row(input op_type op, input int hd, input int cam,
                                     input int tf, input int drv, input int p,
                                     input int d, input int err, input int sat);
      word_row(op, hd, cam, tf);
      stim_table[$].known              = 1'b1;
      stim_table[$].want.drive         = DRIVE_W'(drv);
      stim_table[$].want.p_term        = DRIVE_W'(p);
      stim_table[$].want.d_term        = DTERM_W'(d);
      stim_table[$].want.heading_error = ERR_W'(err);
      stim_table[$].want.saturated     = sat[0];
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? '0 : '1;
         1: return GAIN_W'($urandom_range(0, 1023));
         2: return GAIN_W'($urandom_range(0, 65535));
         default: return GAIN_W'(GAIN_RESET);
      endcase
   endfunction

   task automatic write_regs(input logic [CSR_DATA_W-1:0] t, input logic [CSR_DATA_W-1:0] p,
                             input logic [CSR_DATA_W-1:0] d);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_TARGET;
      csr_wdata <= t;
      @(posedge clock);
      csr_addr  <= CSR_P_GAIN;
      csr_wdata <= p;
      @(posedge clock);
      csr_addr  <= CSR_D_GAIN;
      csr_wdata <= d;
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_target = t[HEADING_W-1:0];
      cfg_p_gain = p;
      cfg_d_gain = d;
   endtask

   // drop valid and wait until every expected word has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (pd_outputs_due.size() != 0) @(posedge clock);
   endtask

   task automatic send_word(input op_type op, input logic [HEADING_W-1:0] hd,
                            input logic signed [CAM_W-1:0] cam, input logic [TF_W-1:0] tf,
                            input bit known, input pd_result_type want);
      pd_result_type model_word;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_heading     <= hd;
      req_cam_offset  <= cam;
      req_time_factor <= tf;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model_word = predict_pd_outputs(op, hd, cam, tf);
      pd_outputs_due.push_back(known ? want : model_word);
   endtask

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset || no_idle) begin
         rsp_ready <= 1'b1;
         rsp_hold  <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_hold  <= $urandom_range(1, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pd_outputs_due.size() == 0) begin
            $error("response word with nothing expected");
            fail_count++;
         end else begin
            head_word = pd_outputs_due.pop_front();
            check_field("drive", head_word.drive, rsp_drive);
            check_field("p_term", head_word.p_term, rsp_p_term);
            check_field("d_term", head_word.d_term, rsp_d_term);
            check_field("heading_error", head_word.heading_error, rsp_heading_error);
            check_field("saturated", head_word.saturated, rsp_saturated);
         end
      end
   end

   initial begin
      stim_row_type            row;
      pd_result_type           none;
      op_type                  op_v;
      logic [HEADING_W-1:0]    hd_v;
      logic signed [CAM_W-1:0] cam_v;
      logic [TF_W-1:0]         tf_v;
      int                      drift;

      // reset defaults: target 0, unity gains; first step sees zero history
      known_row(OP_HOLD,     16,    0,   256,    -2,    -1,   -1,    16, 0);
      known_row(OP_HOLD,   2880,    0,     0,  -150,  -150,    0,  2880, 0);
      known_row(OP_HOLD,   2881,    0,     0,   150,   150,    0, -2879, 0);
      known_row(OP_HOLD,   8191,    0, 65535,  -250,  -150, -100,  2431, 0);
      known_row(OP_CAMERA, 8191,  511,     0,   511,   511,    0,  2431, 0);
      known_row(OP_CAMERA, 8191, -512, 65535,  -512,  -512,    0,  2431, 0);
      known_row(OP_HOLD,      0,    0,   256,   100,     0,  100,     0, 0);
      known_row(OP_HOLD,      0,   -1, 65535,     0,     0,    0,     0, 0);
      // full-scale gains: camera P saturates both ways
      regs_row(5759, 65535, 65535);
      known_row(OP_CAMERA, 5759,  511,     0,  2047,  2047,    0,     0, 1);
      known_row(OP_CAMERA, 5759, -512,     0, -2047, -2047,    0,     0, 1);
      known_row(OP_CAMERA,    0,    1, 65535,   355,   255, -100,     1, 0);
      known_row(OP_HOLD,      0,    0, 65535,   -15,   -15,    0,     1, 0);
      // zero gains
      regs_row(0, 0, 0);
      known_row(OP_HOLD,   2880,    0, 65535,     0,     0,    0,  2880, 0);
      known_row(OP_CAMERA,    0, -512, 65535,     0,     0,    0,     0, 0);
      regs_row(2000, 300, 5000);
      word_row(OP_HOLD,    4880,    0,  1000);
      word_row(OP_HOLD,    4881,  100, 65535);
      word_row(OP_CAMERA,  8191, -300, 12345);
      word_row(OP_CAMERA,  1000,  200, 40000);
      word_row(OP_HOLD,    7000,    5, 65535);
      word_row(OP_HOLD,       0,   -7,   500);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         row = stim_table[i];
         if (row.kind == ROW_REGS) begin
            settle();
            write_regs(row.target, row.p_gain, row.d_gain);
         end else begin
            send_word(row.op, row.heading, row.cam, row.tf, row.known, row.want);
         end
      end

      drift = 0;
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         no_idle <= (ph == 3 || ph == PHASES - 1);
         case (ph)
            0: write_regs(CSR_DATA_W'(5759), '1, '1);
            1: write_regs('0, '0, '0);
            2: write_regs(CSR_DATA_W'($urandom_range(0, 65535)), pick_gain(), pick_gain());
            default: write_regs(CSR_DATA_W'($urandom_range(0, 5759)), pick_gain(),
                                pick_gain());
         endcase
         for (int n = 0; n < PHASE_LEN; n++) begin
            op_v = op_type'($urandom_range(0, 1));
            // mostly slow drift or headings near target
            case ($urandom_range(0, 2))
               0: drift = $urandom_range(0, 8191);
               1: drift = ((int'(cfg_target) + $urandom_range(0, 400) - 200) % FULL_TURN
                           + FULL_TURN) % FULL_TURN;
               default: drift = ((drift + $urandom_range(0, 64) - 32) % FULL_TURN
                                 + FULL_TURN) % FULL_TURN;
            endcase
            hd_v  = HEADING_W'(drift);
            cam_v = CAM_W'($urandom);
            tf_v  = TF_W'($urandom_range(0, 65535) >> $urandom_range(0, 15));
            send_word(op_v, hd_v, cam_v, tf_v, 1'b0, none);
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
